// ===== rtl/ks01_pkg.sv =====
package ks01_pkg;

  localparam int WEIGHT_W = 8;
  localparam int PROFIT_W = 16;
  localparam int BEST_W   = 20;
  localparam int INDEX_W  = 5;
  localparam int CAP_W    = 8;

  localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_BEST_RD,
    ST_BEST_WAIT,
    ST_TB_RD,
    ST_TB_EVAL
  } ks01_state_t;

endpackage

// ===== rtl/knapsack_01_solver.sv =====
// The block solves one 0-1 knapsack problem per run of requests.
// Each input request carries one item (weight, profit, last_item). The item is taken at a
// rising edge with in_valid high and in_stall low. The user must write the capacity
// register through cfg_wr_en and cfg_capacity only while the block is idle; the block does
// not enforce this. The value in force when the traceback starts is the one used.
// For each item one adder and compare unit walks the stored best-profit row once, one column
// per cycle from the top down, and in_stall stays high for the whole walk. The first item of
// a problem treats the old row as zero.
// Items beyond MAX_ITEMS are ignored without a stall and raise the dropped flag; one marked
// last still starts the traceback. After the item marked last, the traceback issues one output
// request per held item, from the last item to the first. After reading the best profit
// (ST_BEST_RD, ST_BEST_WAIT) it steps through ST_TB_RD and ST_TB_EVAL for each result.
// out_last_result marks item one. Results sit in an output register; while out_stall is high
// with a result pending the register holds and the traceback waits. The next problem's items
// are accepted as soon as the final result has been loaded into the output register.
// After reset the capacity is 255, no problem is open and no result is pending.
module knapsack_01_solver #(
  parameter int MAX_ITEMS      = 16,
  parameter int CAPACITY_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ks01_pkg::CAP_W-1:0]      cfg_capacity,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ks01_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic [ks01_pkg::PROFIT_W-1:0]   in_profit,
  input  logic                            in_last_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ks01_pkg::INDEX_W-1:0]    out_item_index,
  output logic                            out_taken,
  output logic [ks01_pkg::BEST_W-1:0]     out_best_profit,
  output logic                            out_dropped_items,
  output logic                            out_last_result
);
  import ks01_pkg::*;

  localparam int CW   = $clog2(CAPACITY_DEPTH);
  localparam int CMPW = (CW > WEIGHT_W) ? CW : WEIGHT_W;
  localparam int IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW   = $clog2(MAX_ITEMS + 1);
  localparam int TK_DEPTH = MAX_ITEMS * (2 ** CW);

  ks01_state_t state_r, state_nxt;

  logic [CAP_W-1:0]    cap_r;
  logic                open_r, open_nxt;
  logic                first_r, first_nxt;
  logic                ovf_r, ovf_nxt;
  logic [NW-1:0]       count_r, count_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic [PROFIT_W-1:0] p_r, p_nxt;
  logic                last_r, last_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [NW-1:0]       i_r, i_nxt;
  logic [BEST_W-1:0]   best_r, best_nxt;

  logic                p1_valid_r;
  logic [CW-1:0]       p1_col_r;
  logic                p1_ok_r;
  logic                p1_bz_r;

  logic                out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic                out_taken_r, out_taken_nxt;
  logic [BEST_W-1:0]   out_best_r, out_best_nxt;
  logic                out_drop_r, out_drop_nxt;
  logic                out_last_r, out_last_nxt;

  logic [BEST_W-1:0]   row_mem [CAPACITY_DEPTH];
  logic [BEST_W-1:0]   row_a_q, row_b_q;
  logic [CW-1:0]       row_addr_a, row_addr_b;
  logic [BEST_W-1:0]   row_wdata;

  logic                tk_mem [TK_DEPTH];
  logic                tk_q;
  logic [IW-1:0]       tb_item;
  logic [WEIGHT_W-1:0] wt_mem [MAX_ITEMS];
  logic [WEIGHT_W-1:0] wt_q;

  logic                in_acc, out_free, room, tb_taken;
  logic [NW-1:0]       count_eff;
  logic [CMPW-1:0]     cap_ext, cap_lim, j_ext, w_ext, col_ext, wq_ext;
  logic [CW-1:0]       cap_col;
  logic [BEST_W-1:0]   a_val, b_val, cand;
  logic [BEST_W:0]     sum;
  logic                take;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign count_eff = open_r ? count_r : '0;
  assign room      = count_eff < NW'(MAX_ITEMS);
  assign cap_ext   = CMPW'(cap_r);
  assign cap_lim   = CMPW'(CAPACITY_DEPTH - 1);
  assign cap_col   = (cap_ext > cap_lim) ? CW'(cap_lim) : CW'(cap_ext);
  assign j_ext     = CMPW'(j_r);
  assign w_ext     = CMPW'(w_r);
  assign col_ext   = CMPW'(col_r);
  assign wq_ext    = CMPW'(wt_q);
  assign tb_item   = IW'(i_r - NW'(1));
  assign tb_taken  = (col_r != '0) && tk_q;

  // Compare and update for one column of the row.
  assign a_val     = first_r ? '0 : row_a_q;
  assign b_val     = (first_r || p1_bz_r) ? '0 : row_b_q;
  assign sum       = {1'b0, b_val} + (BEST_W+1)'(p_r);
  assign cand      = (sum > (BEST_W+1)'(BEST_MAX)) ? BEST_MAX : sum[BEST_W-1:0];
  assign take      = p1_ok_r && (cand > a_val);
  assign row_wdata = take ? cand : a_val;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (room) begin
            state_nxt = ST_SWEEP;
          end else if (in_last_item) begin
            state_nxt = ST_BEST_RD;
          end
        end
      end
      ST_SWEEP: begin
        if (j_r == CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_BEST_RD : ST_IDLE;
      end
      ST_BEST_RD: begin
        state_nxt = ST_BEST_WAIT;
      end
      ST_BEST_WAIT: begin
        state_nxt = ST_TB_RD;
      end
      ST_TB_RD: begin
        state_nxt = ST_TB_EVAL;
      end
      ST_TB_EVAL: begin
        if (out_free) begin
          state_nxt = (i_r == NW'(1)) ? ST_IDLE : ST_TB_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    row_addr_a    = (state_r == ST_BEST_RD) ? cap_col : j_r;
    row_addr_b    = CW'(j_ext - w_ext);
    open_nxt      = open_r;
    first_nxt     = first_r;
    ovf_nxt       = ovf_r;
    count_nxt     = count_r;
    w_nxt         = w_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    col_nxt       = col_r;
    i_nxt         = i_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_index_nxt = out_index_r;
    out_taken_nxt = out_taken_r;
    out_best_nxt  = out_best_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          open_nxt  = 1'b1;
          count_nxt = count_eff;
          w_nxt     = in_weight;
          p_nxt     = in_profit;
          last_nxt  = in_last_item;
          j_nxt     = CW'(CAPACITY_DEPTH - 1);
          if (!open_r) begin
            first_nxt = 1'b1;
            ovf_nxt   = 1'b0;
          end
          if (!room) begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        j_nxt = j_r - CW'(1);
      end
      ST_DRAIN: begin
        count_nxt = count_r + NW'(1);
        first_nxt = 1'b0;
      end
      ST_BEST_RD: begin
        col_nxt = cap_col;
        i_nxt   = count_r;
      end
      ST_BEST_WAIT: begin
        best_nxt = (col_r == '0) ? '0 : row_a_q;
      end
      ST_TB_RD: begin
      end
      ST_TB_EVAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = INDEX_W'(i_r);
          out_taken_nxt = tb_taken;
          out_best_nxt  = best_r;
          out_drop_nxt  = ovf_r;
          out_last_nxt  = (i_r == NW'(1));
          if (tb_taken && (col_ext >= wq_ext)) begin
            col_nxt = CW'(col_ext - wq_ext);
          end
          i_nxt = i_r - NW'(1);
          if (i_r == NW'(1)) begin
            open_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
            count_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_W'(255);
      open_r      <= 1'b0;
      first_r     <= 1'b0;
      ovf_r       <= 1'b0;
      count_r     <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_capacity;
      end
      open_r      <= open_nxt;
      first_r     <= first_nxt;
      ovf_r       <= ovf_nxt;
      count_r     <= count_nxt;
      p1_valid_r  <= (state_r == ST_SWEEP);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    p_r         <= p_nxt;
    last_r      <= last_nxt;
    j_r         <= j_nxt;
    col_r       <= col_nxt;
    i_r         <= i_nxt;
    best_r      <= best_nxt;
    p1_col_r    <= j_r;
    p1_ok_r     <= (j_ext >= w_ext);
    p1_bz_r     <= (j_ext == w_ext);
    out_index_r <= out_index_nxt;
    out_taken_r <= out_taken_nxt;
    out_best_r  <= out_best_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (p1_valid_r) begin
      row_mem[p1_col_r] <= row_wdata;
    end
    row_a_q <= row_mem[row_addr_a];
    row_b_q <= row_mem[row_addr_b];
  end

  always_ff @(posedge clk) begin
    if (p1_valid_r) begin
      tk_mem[{count_r[IW-1:0], p1_col_r}] <= take;
    end
    tk_q <= tk_mem[{tb_item, col_r}];
  end

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      wt_mem[count_eff[IW-1:0]] <= in_weight;
    end
    wt_q <= wt_mem[tb_item];
  end

  assign out_valid         = out_valid_r;
  assign out_item_index    = out_index_r;
  assign out_taken         = out_taken_r;
  assign out_best_profit   = out_best_r;
  assign out_dropped_items = out_drop_r;
  assign out_last_result   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_ITEMS))
    else $error("Item count exceeds the item limit.");

  a_no_col_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> (p1_col_r != '0))
    else $error("Column zero of the row was written.");

  a_sweep_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (open_r && (count_r < NW'(MAX_ITEMS))))
    else $error("Sweep started without room for the item.");

  a_tb_has_items: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TB_EVAL) |-> (i_r != '0))
    else $error("Traceback ran past item one.");

  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TB_EVAL && out_free && i_r == NW'(1)) |=>
      (!open_r && out_valid_r && out_last_r))
    else $error("Problem not closed after the final result.");

endmodule
